FILE: hw/rtl/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared constants and types for the selection sorter.
// ----------------------------------------------------------------------------
package ssort_pkg;

	localparam int DEPTH   = 16;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ROT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// One slot of the ring: occupancy flag and the held element.
	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] value;
	} cell_t;

endpackage

FILE: hw/rtl/ssort_cell.sv
// ----------------------------------------------------------------------------
// ssort_cell
// One slot of the element ring; takes its neighbour's slot on each shift.
// ----------------------------------------------------------------------------
module ssort_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ssort_pkg::cell_t d,
	output ssort_pkg::cell_t q
);

	logic                               valid_q;
	logic signed [ssort_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (en && d.valid) begin
			value_q <= d.value;
		end
	end

	assign q.valid = valid_q;
	assign q.value = value_q;

endmodule

FILE: hw/rtl/ssort_xchg.sv
// ----------------------------------------------------------------------------
// ssort_xchg
// Compare-exchange at the ring's tail: keeps the smallest element seen in a
// hold register and passes the larger one (or an empty slot) back to the head.
// ----------------------------------------------------------------------------
module ssort_xchg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  ssort_pkg::cell_t tail,
	output ssort_pkg::cell_t head,
	output ssort_pkg::cell_t hold
);

	logic                               hold_valid_q;
	logic signed [ssort_pkg::VAL_W-1:0] hold_value_q;
	ssort_pkg::cell_t                   hold_q;
	ssort_pkg::cell_t                   hold_d;

	assign hold_q.valid = hold_valid_q;
	assign hold_q.value = hold_value_q;

	always_comb begin
		hold_d = hold_q;
		head   = tail;
		if (tail.valid) begin
			if (!hold_q.valid) begin
				hold_d     = tail;
				head.valid = 1'b0;
			end else if (tail.value < hold_q.value) begin
				hold_d = tail;
				head   = hold_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (clr) begin
			hold_valid_q <= 1'b0;
		end else if (en) begin
			hold_valid_q <= hold_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !clr) begin
			hold_value_q <= hold_d.value;
		end
	end

	assign hold = hold_q;

endmodule

FILE: hw/rtl/selection_sorter_top.sv
// ----------------------------------------------------------------------------
// selection_sorter_top
// Batch sorter: collects signed elements, then returns them smallest first.
// ----------------------------------------------------------------------------
// Usage:
//  - Input transfer: start high while busy is low. value is stored, is_last
//    closes the batch. busy stays low after a non-final element.
//  - Up to DEPTH elements are held in a ring of cells. Further elements are
//    dropped and every result of that batch then carries overflow.
//  - After is_last, busy rises. Each result needs one full turn of the ring
//    through the compare-exchange unit at its tail, then a state in which
//    strobe is high. Results come one per turn of the ring because the
//    exchange unit holds a single comparator.
//  - Each result is presented for exactly one cycle with strobe; the last one
//    carries is_final. The receiver cannot stall, so none is held back.
//  - busy falls in the cycle after the final result; a new batch may start.
//  - Reset empties the ring, clears the count and the overflow flag.
// ----------------------------------------------------------------------------
module selection_sorter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic        is_last,
	output logic        strobe,
	output logic [31:0] sorted_value,
	output logic        is_final,
	output logic        overflow
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [ssort_pkg::CNT_W-1:0] CNT_FULL = ssort_pkg::CNT_W'(ssort_pkg::DEPTH);
	localparam logic [ssort_pkg::CNT_W-1:0] CNT_ONE  = ssort_pkg::CNT_W'(1);
	localparam logic [ssort_pkg::ROT_W-1:0] ROT_LAST = ssort_pkg::ROT_W'(ssort_pkg::DEPTH - 1);
	localparam logic [ssort_pkg::ROT_W-1:0] ROT_ONE  = ssort_pkg::ROT_W'(1);

	logic [1:0]                   state_q;
	logic [ssort_pkg::CNT_W-1:0]  count_q;   // elements held / still to emit
	logic [ssort_pkg::ROT_W-1:0]  rot_q;     // position within one ring turn
	logic                         drop_q;

	logic             accept;
	logic             store;
	logic             scanning;
	logic             shift_en;
	ssort_pkg::cell_t head_d;
	ssort_pkg::cell_t xchg_head;
	ssort_pkg::cell_t hold;
	ssort_pkg::cell_t chain [ssort_pkg::DEPTH+1];

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign store    = accept && (count_q != CNT_FULL);
	assign scanning = (state_q == ST_SCAN);
	assign shift_en = store || scanning;

	// head of the ring: new element while loading, exchange output while sorting
	always_comb begin
		if (scanning) begin
			head_d = xchg_head;
		end else begin
			head_d.valid = 1'b1;
			head_d.value = value;
		end
	end

	assign chain[0] = head_d;

	for (genvar i = 0; i < ssort_pkg::DEPTH; i++) begin : g_cell
		ssort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (shift_en),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	ssort_xchg u_xchg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (scanning),
		.clr    (state_q == ST_EMIT),
		.tail   (chain[ssort_pkg::DEPTH]),
		.head   (xchg_head),
		.hold   (hold)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rot_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store) begin
							count_q <= count_q + CNT_ONE;
						end else begin
							drop_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= ST_SCAN;
							rot_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					// one full turn brings the minimum into the hold register
					rot_q <= rot_q + ROT_ONE;
					if (rot_q == ROT_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					count_q <= count_q - CNT_ONE;
					rot_q   <= '0;
					if (count_q == CNT_ONE) begin
						state_q <= ST_IDLE;
						drop_q  <= 1'b0;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe       = (state_q == ST_EMIT);
	assign sorted_value = hold.value;
	assign is_final     = (count_q == CNT_ONE);
	assign overflow     = drop_q;

endmodule
